FILE: design/nta_pkg.sv
`timescale 1ns / 1ps

package nta_pkg;

    // Default table depth
    localparam int TRACKS_DEF = 64;

    // Field widths
    localparam int TIME_W  = 32;
    localparam int ID_W    = 32;
    localparam int COORD_W = 24;
    localparam int AREA_W  = 32;
    localparam int DIST_W  = 16;
    localparam int CNT_W   = 7;
    localparam int CFG_W   = 32;
    localparam int CFGA_W  = 2;

    // Squared-distance arithmetic
    localparam int SQ_W  = 2 * COORD_W;
    localparam int SUM_W = SQ_W + 2;

    // Register reset values
    localparam logic [DIST_W-1:0] MATCH_DIST_RST = 16'd256;
    localparam logic [TIME_W-1:0] DROP_AGE_RST   = 32'd1000;
    localparam logic [AREA_W-1:0] AREA_LIMIT_RST = 32'd25600000;

    // Result status codes
    typedef enum logic [2:0] {
        ST_MATCH  = 3'd0,
        ST_NEW    = 3'd1,
        ST_REJECT = 3'd2,
        ST_FULL   = 3'd3,
        ST_FRAME  = 3'd4
    } t_status;

    // Configuration register indexes
    typedef enum logic [CFGA_W-1:0] {
        CFG_MATCH_DIST = 2'd0,
        CFG_DROP_AGE   = 2'd1,
        CFG_AREA_LIMIT = 2'd2
    } t_cfg_idx;

    // Input op codes
    localparam logic OP_FRAME   = 1'b0;
    localparam logic OP_CLUSTER = 1'b1;

endpackage

FILE: design/nearest_track_association_top.sv
`timescale 1ns / 1ps

// Channel   | Dir | Handshake                      | Payload
// ----------+-----+--------------------------------+---------------------------------------
// s_axis    | in  | s_axis_tvalid / s_axis_tready  | tuser: op; tdata: time,id,x,y,z,area
// m_axis    | out | m_axis_tvalid / m_axis_tready  | tuser: status; tdata: id,dropped,active
// cfg       | in  | i_cfg_we (no wait)             | i_cfg_addr, i_cfg_wdata
//
// A frame start makes one pass of the age compare over the seen-time memory.
// A cluster sends one slot a cycle through the shared distance pipeline
// (read, abs difference, square, sum and compare), then the table update; a match then reads
// the id from the id memory. A rejected cluster skips the scan. Exactly one result per request.
// i_rst_n is synchronous, active low; it clears the slot flags, counts and registers at once.
// A result waits in the output register; the next request is taken meanwhile.

module nearest_track_association_top
    import nta_pkg::*;
#(
    parameter int TRACKS = TRACKS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave side
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [0] op
    input  logic [0:0]   s_axis_tuser,
    // [31:0] frame_time, [63:32] raw_id, [87:64] avg_x, [111:88] avg_y,
    // [135:112] avg_z, [167:136] area
    input  logic [167:0] s_axis_tdata,
    // master side
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [2:0] status
    output logic [2:0]   m_axis_tuser,
    // [31:0] track_id, [38:32] dropped_count, [45:39] active_count, [47:46] zero
    output logic [47:0]  m_axis_tdata,
    // configuration
    input  logic              i_cfg_we,
    input  logic [CFGA_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]  i_cfg_wdata
);

    localparam int IW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int CW = $clog2(TRACKS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(TRACKS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FSCAN,
        S_CSCAN,
        S_FIN,
        S_CID,
        S_OUT
    } t_state;

    // Count saturated to the 7-bit output field
    function automatic logic [CNT_W-1:0] sat_cnt(input logic [CW-1:0] n);
        if (32'(n) > 32'd127) begin
            return 7'd127;
        end
        return CNT_W'(n);
    endfunction

    // ---------------- configuration ----------------
    logic [DIST_W-1:0] r_match_dist;
    logic [TIME_W-1:0] r_drop_age;
    logic [AREA_W-1:0] r_area_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_dist <= MATCH_DIST_RST;
            r_drop_age   <= DROP_AGE_RST;
            r_area_limit <= AREA_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_MATCH_DIST: r_match_dist <= i_cfg_wdata[DIST_W-1:0];
                CFG_DROP_AGE:   r_drop_age   <= i_cfg_wdata[TIME_W-1:0];
                CFG_AREA_LIMIT: r_area_limit <= i_cfg_wdata[AREA_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- input unpack ----------------
    logic                             w_acc;
    logic                             w_op;
    logic [TIME_W-1:0]                w_in_time;
    logic [ID_W-1:0]                  w_in_id;
    logic [2:0][COORD_W-1:0]          w_in_pt;
    logic [AREA_W-1:0]                w_in_area;

    assign w_acc     = s_axis_tvalid && s_axis_tready;
    assign w_op      = s_axis_tuser[0];
    assign w_in_time = s_axis_tdata[31:0];
    assign w_in_id   = s_axis_tdata[63:32];
    assign w_in_pt   = s_axis_tdata[135:64];
    assign w_in_area = s_axis_tdata[167:136];

    // ---------------- control state ----------------
    t_state              r_state;
    logic [TRACKS-1:0]   r_valid;
    logic [TRACKS-1:0]   r_pend;
    logic [TRACKS-1:0]   r_chos;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_drop;
    logic [TIME_W-1:0]   r_now;
    logic                r_op;
    logic [ID_W-1:0]     r_raw_id;
    logic [2:0][COORD_W-1:0] r_p;
    logic [2*DIST_W-1:0] r_limit;

    // scan issue and pipeline tags
    logic                r_iss_on;
    logic [IW-1:0]       r_idx;
    logic                r_t1_vld, r_t2_vld, r_t3_vld;
    logic [IW-1:0]       r_t1_idx, r_t2_idx, r_t3_idx;
    logic                r_t1_elig, r_t2_elig, r_t3_elig;
    logic                r_t1_free, r_t2_free, r_t3_free;

    // search results
    logic                r_found;
    logic [SUM_W-1:0]    r_best;
    logic [IW-1:0]       r_best_slot;
    logic                r_free_ok;
    logic [IW-1:0]       r_free_slot;

    // pending result and output register
    t_status             r_res_status;
    logic [ID_W-1:0]     r_res_id;
    logic                r_o_valid;
    t_status             r_o_status;
    logic [ID_W-1:0]     r_o_id;
    logic [CNT_W-1:0]    r_o_drop;
    logic [CNT_W-1:0]    r_o_act;

    // ---------------- memories ----------------
    logic [ID_W-1:0]         r_mem_id   [TRACKS];
    logic [3*COORD_W-1:0]    r_mem_pt   [TRACKS];
    logic [TIME_W-1:0]       r_mem_seen [TRACKS];
    logic [ID_W-1:0]         r_rd_id;
    logic [2:0][COORD_W-1:0] r_rd_pt;
    logic [TIME_W-1:0]       r_rd_seen;

    logic          w_we_id;
    logic          w_we_pt;
    logic [IW-1:0] w_waddr;
    logic [IW-1:0] w_raddr;

    assign w_we_pt = (r_state == S_FIN) && (r_found || r_free_ok);
    assign w_we_id = (r_state == S_FIN) && !r_found && r_free_ok;
    assign w_waddr = r_found ? r_best_slot : r_free_slot;
    assign w_raddr = (r_state == S_FIN) ? r_best_slot : r_idx;

    always_ff @(posedge i_clk) begin
        if (w_we_id) begin
            r_mem_id[w_waddr] <= r_raw_id;
        end
        r_rd_id <= r_mem_id[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_we_pt) begin
            r_mem_pt[w_waddr] <= r_p;
        end
        r_rd_pt <= r_mem_pt[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_we_pt) begin
            r_mem_seen[w_waddr] <= r_now;
        end
        r_rd_seen <= r_mem_seen[w_raddr];
    end

    // ---------------- shared distance pipeline ----------------
    logic [2:0][COORD_W-1:0] r_ad;
    logic [2:0][SQ_W-1:0]    r_sq;
    logic [SUM_W-1:0]        w_sum;
    logic [SUM_W-1:0]        w_lim;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            logic [COORD_W:0] d;
            d = {r_rd_pt[k][COORD_W-1], r_rd_pt[k]} - {r_p[k][COORD_W-1], r_p[k]};
            // magnitude fits in COORD_W bits
            r_ad[k] <= COORD_W'(d[COORD_W] ? -d : d);
            r_sq[k] <= SQ_W'(r_ad[k]) * SQ_W'(r_ad[k]);
        end
    end

    assign w_sum = SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
    assign w_lim = r_found ? r_best : SUM_W'(r_limit);

    // age of the slot whose seen time was just read
    logic [TIME_W-1:0] w_age;
    assign w_age = r_now - r_rd_seen;

    logic w_out_free;
    assign w_out_free = !r_o_valid || m_axis_tready;

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_pend    <= '0;
            r_chos    <= '0;
            r_count   <= '0;
            r_drop    <= '0;
            r_now     <= '0;
            r_iss_on  <= 1'b0;
            r_idx     <= '0;
            r_t1_vld  <= 1'b0;
            r_t2_vld  <= 1'b0;
            r_t3_vld  <= 1'b0;
            r_found   <= 1'b0;
            r_free_ok <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            // slot issue, one per cycle
            if (r_iss_on) begin
                r_idx <= r_idx + IW'(1);
                if (r_idx == LAST_IDX) begin
                    r_iss_on <= 1'b0;
                end
            end
            r_t1_vld  <= r_iss_on;
            r_t1_idx  <= r_idx;
            r_t1_elig <= r_valid[r_idx] && !r_pend[r_idx] && !r_chos[r_idx];
            r_t1_free <= !r_valid[r_idx];
            r_t2_vld  <= r_t1_vld;
            r_t2_idx  <= r_t1_idx;
            r_t2_elig <= r_t1_elig;
            r_t2_free <= r_t1_free;
            r_t3_vld  <= r_t2_vld;
            r_t3_idx  <= r_t2_idx;
            r_t3_elig <= r_t2_elig;
            r_t3_free <= r_t2_free;

            // output register drains independently; S_OUT reloads it itself
            if (m_axis_tready && (r_state != S_OUT)) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_op     <= w_op;
                        r_raw_id <= w_in_id;
                        r_p      <= w_in_pt;
                        r_limit  <= (2*DIST_W)'(r_match_dist) * (2*DIST_W)'(r_match_dist);
                        r_found  <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_idx    <= '0;
                        if (w_op == OP_FRAME) begin
                            r_now    <= w_in_time;
                            r_pend   <= '0;
                            r_chos   <= '0;
                            r_drop   <= '0;
                            r_iss_on <= 1'b1;
                            r_state  <= S_FSCAN;
                        end else if (w_in_area > r_area_limit) begin
                            r_res_status <= ST_REJECT;
                            r_res_id     <= w_in_id;
                            r_state      <= S_OUT;
                        end else begin
                            r_iss_on <= 1'b1;
                            r_state  <= S_CSCAN;
                        end
                    end
                end

                // stale-track sweep: age compare on each read seen time
                S_FSCAN: begin
                    if (r_t1_vld) begin
                        if (r_valid[r_t1_idx] && (w_age >= r_drop_age)) begin
                            r_valid[r_t1_idx] <= 1'b0;
                            r_drop  <= r_drop + CW'(1);
                            r_count <= r_count - CW'(1);
                        end
                        if (r_t1_idx == LAST_IDX) begin
                            r_res_status <= ST_FRAME;
                            r_res_id     <= '0;
                            r_state      <= S_OUT;
                        end
                    end
                end

                // nearest search and first free slot
                S_CSCAN: begin
                    if (r_t3_vld) begin
                        if (r_t3_elig && (w_sum < w_lim)) begin
                            r_found     <= 1'b1;
                            r_best      <= w_sum;
                            r_best_slot <= r_t3_idx;
                        end
                        if (r_t3_free && !r_free_ok) begin
                            r_free_ok   <= 1'b1;
                            r_free_slot <= r_t3_idx;
                        end
                        if (r_t3_idx == LAST_IDX) begin
                            r_state <= S_FIN;
                        end
                    end
                end

                // table update; memories are written from this state
                S_FIN: begin
                    if (r_found) begin
                        r_chos[r_best_slot] <= 1'b1;
                        r_res_status        <= ST_MATCH;
                        r_state             <= S_CID;
                    end else if (r_free_ok) begin
                        r_valid[r_free_slot] <= 1'b1;
                        r_pend[r_free_slot]  <= 1'b1;
                        r_chos[r_free_slot]  <= 1'b0;
                        r_count      <= r_count + CW'(1);
                        r_res_status <= ST_NEW;
                        r_res_id     <= r_raw_id;
                        r_state      <= S_OUT;
                    end else begin
                        r_res_status <= ST_FULL;
                        r_res_id     <= r_raw_id;
                        r_state      <= S_OUT;
                    end
                end

                // matched track's id arrives from the id memory
                S_CID: begin
                    r_res_id <= r_rd_id;
                    r_state  <= S_OUT;
                end

                S_OUT: begin
                    if (w_out_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_status <= r_res_status;
                        r_o_id     <= r_res_id;
                        r_o_drop   <= (r_op == OP_FRAME) ? sat_cnt(r_drop) : '0;
                        r_o_act    <= sat_cnt(r_count);
                        r_state    <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ---------------- outputs ----------------
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tuser  = r_o_status;
    assign m_axis_tdata  = {2'b00, r_o_act, r_o_drop, r_o_id};

    // ---------------- assertions ----------------
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'($countones(r_valid)) == 32'(r_count))
        else $error("entry count differs from valid flags");

    a_pend_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend & ~r_valid) == '0)
        else $error("pending flag on an empty slot");

    a_chos_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_chos & r_pend) == '0)
        else $error("slot both pending and chosen");

    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (w_op == OP_FRAME)) |=> (r_pend == '0) && (r_chos == '0))
        else $error("frame start did not clear pending and chosen flags");

    a_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> !s_axis_tready)
        else $error("request taken while the previous one is still at work");

endmodule
